@@ rtl/fdtd_acoustic_cell_update_defines.svh @@
// Assertion macros shared by the FDTD cell update RTL.
`ifndef FDTD_ACOUSTIC_CELL_UPDATE_DEFINES_SVH
`define FDTD_ACOUSTIC_CELL_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FDTDAC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FDTDAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fdtdac_pkg.sv @@
// Shared types, widths and register codes for the FDTD cell update block.
package fdtdac_pkg;

   localparam int VAL_W   = 16;
   localparam int K_W     = 3;
   localparam int U2_W    = 20;
   localparam int EP_W    = 32;
   localparam int RECIP_W = 16;
   localparam int NUM_W   = 38;
   localparam int LO_W    = 19;
   localparam int HI_W    = NUM_W - LO_W;
   localparam int PLO_W   = LO_W + RECIP_W;
   localparam int PHI_W   = HI_W + RECIP_W + 1;
   localparam int PROD_W  = 56;
   localparam int RND_SHIFT = 17 + RECIP_W;
   localparam int Y_W     = PROD_W - RND_SHIFT;
   localparam int VAL_MAX = 32767;
   localparam int VAL_MIN = -32768;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_EMITTANCE    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RECIP_ONE    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RECIP_TWO    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RECIP_THREE  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_RECIP_FOUR   = 3'd4;

   localparam logic [RECIP_W-1:0] EMITTANCE_RST    = 16'd21845;
   localparam logic [RECIP_W-1:0] RECIP_ONE_RST    = 16'd49152;
   localparam logic [RECIP_W-1:0] RECIP_TWO_RST    = 16'd39322;
   localparam logic [RECIP_W-1:0] RECIP_THREE_RST  = 16'd32768;
   localparam logic [RECIP_W-1:0] RECIP_FOUR_RST   = 16'd28087;

   typedef struct packed {
      logic signed [VAL_W-1:0] center_value;
      logic signed [VAL_W-1:0] previous_value;
      logic signed [VAL_W-1:0] north_value;
      logic signed [VAL_W-1:0] south_value;
      logic signed [VAL_W-1:0] west_value;
      logic signed [VAL_W-1:0] east_value;
      logic [K_W-1:0]          open_neighbours;
      logic                    solid;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] next_value;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic [RECIP_W-1:0] emittance;
      logic [RECIP_W-1:0] recip_one;
      logic [RECIP_W-1:0] recip_two;
      logic [RECIP_W-1:0] recip_three;
      logic [RECIP_W-1:0] recip_four;
   } cfg_type;

   // After the first stage: doubled lossless update and E*p.
   typedef struct packed {
      logic signed [U2_W-1:0]  u2;
      logic signed [EP_W-1:0]  ep;
      logic [K_W-1:0]          missing;
      logic                    solid;
      logic signed [VAL_W-1:0] center;
   } lap_type;

   // After the second stage: loss numerator and the chosen reciprocal.
   typedef struct packed {
      logic signed [NUM_W-1:0] num;
      logic [RECIP_W-1:0]      recip;
      logic signed [U2_W-1:0]  u2;
      logic                    lossless;
      logic                    solid;
      logic signed [VAL_W-1:0] center;
   } num_type;

   // After the third stage: the two partial products.
   typedef struct packed {
      logic [PLO_W-1:0]        plo;
      logic signed [PHI_W-1:0] phi;
      logic signed [U2_W-1:0]  u2;
      logic                    lossless;
      logic                    solid;
      logic signed [VAL_W-1:0] center;
   } mul_type;

endpackage

@@ rtl/fdtdac_csr.sv @@
// Configuration register file with an APB-style access port.
module fdtdac_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fdtdac_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fdtdac_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fdtdac_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                               csr_pready,
   output fdtdac_pkg::cfg_type                cfg
);
   import fdtdac_pkg::*;

   cfg_type                cfg_ff;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic [RECIP_W-1:0]     wdata;
   logic [RECIP_W-1:0]     rdata;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wdata      = csr_pwdata[RECIP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.emittance   <= EMITTANCE_RST;
         cfg_ff.recip_one   <= RECIP_ONE_RST;
         cfg_ff.recip_two   <= RECIP_TWO_RST;
         cfg_ff.recip_three <= RECIP_THREE_RST;
         cfg_ff.recip_four  <= RECIP_FOUR_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_EMITTANCE:   cfg_ff.emittance   <= wdata;
            REG_RECIP_ONE:   cfg_ff.recip_one   <= wdata;
            REG_RECIP_TWO:   cfg_ff.recip_two   <= wdata;
            REG_RECIP_THREE: cfg_ff.recip_three <= wdata;
            REG_RECIP_FOUR:  cfg_ff.recip_four  <= wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_EMITTANCE:   rdata = cfg_ff.emittance;
         REG_RECIP_ONE:   rdata = cfg_ff.recip_one;
         REG_RECIP_TWO:   rdata = cfg_ff.recip_two;
         REG_RECIP_THREE: rdata = cfg_ff.recip_three;
         REG_RECIP_FOUR:  rdata = cfg_ff.recip_four;
         default:         rdata = '0;
      endcase
   end

   assign csr_prdata = CSR_DATA_W'(rdata);
   assign cfg        = cfg_ff;

endmodule

@@ rtl/fdtdac_front.sv @@
// First two pipeline stages: stencil sum, E*p product, loss numerator and reciprocal select.
`include "fdtd_acoustic_cell_update_defines.svh"
module fdtdac_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  fdtdac_pkg::req_type  in_data,
   input  fdtdac_pkg::cfg_type  cfg,
   output logic                 out_valid,
   input  logic                 out_stall,
   output fdtdac_pkg::num_type  out_data
);
   import fdtdac_pkg::*;

   logic                    s1_v_ff;
   lap_type                 s1_ff;
   lap_type                 s1_in;
   logic                    s1_adv;
   logic                    s2_v_ff;
   num_type                 s2_ff;
   num_type                 s2_in;
   logic                    s2_adv;

   logic [K_W-1:0]          k_clip;
   logic [K_W-1:0]          missing;
   logic signed [U2_W-1:0]  c_x;
   logic signed [U2_W-1:0]  p_x;
   logic signed [U2_W-1:0]  nb;
   logic signed [U2_W-1:0]  mc;
   logic signed [RECIP_W:0] e_s;
   logic signed [NUM_W-1:0] ep_x;
   logic signed [NUM_W-1:0] em2;

   // Stage one: doubled lossless update and the emittance product.
   always_comb begin
      k_clip  = (in_data.open_neighbours > 3'd4) ? 3'd4 : in_data.open_neighbours;
      missing = 3'd4 - k_clip;
      c_x = U2_W'(in_data.center_value);
      p_x = U2_W'(in_data.previous_value);
      nb  = U2_W'(in_data.north_value) + U2_W'(in_data.south_value)
          + U2_W'(in_data.west_value) + U2_W'(in_data.east_value);
      case (missing)
         3'd0:    mc = '0;
         3'd1:    mc = c_x;
         3'd2:    mc = c_x <<< 1;
         3'd3:    mc = (c_x <<< 1) + c_x;
         default: mc = c_x <<< 2;
      endcase
      e_s = $signed({1'b0, cfg.emittance});
      s1_in.u2      = mc + nb - (p_x <<< 1);
      s1_in.ep      = EP_W'(e_s) * EP_W'(in_data.previous_value);
      s1_in.missing = missing;
      s1_in.solid   = in_data.solid;
      s1_in.center  = in_data.center_value;
   end

   // Stage two: numerator 2u*2^16 + 2*E*m*p and the reciprocal for m.
   always_comb begin
      ep_x = NUM_W'(s1_ff.ep);
      case (s1_ff.missing)
         3'd1:    em2 = ep_x <<< 1;
         3'd2:    em2 = ep_x <<< 2;
         3'd3:    em2 = (ep_x <<< 2) + (ep_x <<< 1);
         3'd4:    em2 = ep_x <<< 3;
         default: em2 = '0;
      endcase
      case (s1_ff.missing)
         3'd1:    s2_in.recip = cfg.recip_one;
         3'd2:    s2_in.recip = cfg.recip_two;
         3'd3:    s2_in.recip = cfg.recip_three;
         default: s2_in.recip = cfg.recip_four;
      endcase
      s2_in.num      = (NUM_W'(s1_ff.u2) <<< RECIP_W) + em2;
      s2_in.u2       = s1_ff.u2;
      s2_in.lossless = (s1_ff.missing == 3'd0);
      s2_in.solid    = s1_ff.solid;
      s2_in.center   = s1_ff.center;
   end

   assign s2_adv   = !s2_v_ff || !out_stall;
   assign s1_adv   = !s1_v_ff || s2_adv;
   assign in_stall = !s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_v_ff <= in_valid;
         end
         if (s2_adv) begin
            s2_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && in_valid) begin
         s1_ff <= s1_in;
      end
      if (s2_adv && s1_v_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_data  = s2_ff;

   `FDTDAC_ASSERT_SAME(a_missing_range, clock, reset, s1_v_ff, s1_ff.missing <= 3'd4, "missing-neighbour count above four")

endmodule

@@ rtl/fdtdac_mul.sv @@
// Third pipeline stage: numerator times reciprocal as two partial products.
module fdtdac_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  fdtdac_pkg::num_type  in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output fdtdac_pkg::mul_type  out_data
);
   import fdtdac_pkg::*;

   logic                     v_ff;
   mul_type                  d_ff;
   mul_type                  d_in;
   logic                     adv;
   logic [LO_W-1:0]          lo;
   logic signed [HI_W-1:0]   hi;
   logic signed [RECIP_W:0]  r_s;

   // The signed numerator splits into an unsigned low slice and a signed
   // high slice so each multiplier stays near 19 by 17 bits.
   always_comb begin
      lo  = in_data.num[LO_W-1:0];
      hi  = $signed(in_data.num[NUM_W-1:LO_W]);
      r_s = $signed({1'b0, in_data.recip});
      d_in.plo      = PLO_W'(lo) * PLO_W'(in_data.recip);
      d_in.phi      = PHI_W'(hi) * PHI_W'(r_s);
      d_in.u2       = in_data.u2;
      d_in.lossless = in_data.lossless;
      d_in.solid    = in_data.solid;
      d_in.center   = in_data.center;
   end

   assign adv      = !v_ff || !out_stall;
   assign in_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

@@ rtl/fdtdac_out.sv @@
// Last pipeline stage: product sum, floor rounding, saturation, result register.
`include "fdtd_acoustic_cell_update_defines.svh"
module fdtdac_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  fdtdac_pkg::mul_type  in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output fdtdac_pkg::rsp_type  out_data
);
   import fdtdac_pkg::*;

   localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(VAL_MAX);
   localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(VAL_MIN);

   logic                     v_ff;
   rsp_type                  d_ff;
   rsp_type                  d_in;
   logic                     adv;
   logic signed [PROD_W-1:0] phi_x;
   logic signed [PROD_W-1:0] plo_x;
   logic signed [PROD_W-1:0] prod;
   logic signed [Y_W-1:0]    y;

   // Arithmetic right shifts floor toward minus infinity.
   always_comb begin
      phi_x = PROD_W'(in_data.phi);
      plo_x = PROD_W'(in_data.plo);
      prod  = (phi_x <<< LO_W) + plo_x;
      if (in_data.lossless) begin
         y = Y_W'(in_data.u2 >>> 1);
      end else begin
         y = $signed(prod[PROD_W-1:RND_SHIFT]);
      end
      if (in_data.solid) begin
         d_in.next_value = in_data.center;
         d_in.saturated  = 1'b0;
      end else if (y > Y_MAX) begin
         d_in.next_value = VAL_W'(VAL_MAX);
         d_in.saturated  = 1'b1;
      end else if (y < Y_MIN) begin
         d_in.next_value = VAL_W'(VAL_MIN);
         d_in.saturated  = 1'b1;
      end else begin
         d_in.next_value = y[VAL_W-1:0];
         d_in.saturated  = 1'b0;
      end
   end

   assign adv      = !v_ff || !out_stall;
   assign in_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

   `FDTDAC_ASSERT_SAME(a_sat_at_rail, clock, reset, v_ff && d_ff.saturated, (d_ff.next_value == VAL_W'(VAL_MAX)) || (d_ff.next_value == VAL_W'(VAL_MIN)), "saturated result not at a rail")

endmodule

@@ rtl/fdtd_acoustic_cell_update.sv @@
// Top level of the pipelined 2D acoustic FDTD cell update with wall loss.
// Each req_ transaction carries one cell: its current and previous pressure,
// its four neighbours' pressures, its open-neighbour count and a solid flag.
// Each one yields exactly one rsp_ transaction with the next pressure and a
// flag that tells whether the value was clipped to the Q4.11 range.
// The datapath is a four-stage pipeline: stencil sum and E*p multiply, loss
// numerator and reciprocal select, split numerator-by-reciprocal multiply,
// then product sum, floor rounding and saturation into the result register.
// A new transaction is taken every cycle while rsp_stall does not hold the
// pipeline; the two narrow multipliers of stage three set the clock period.
// Each stage holds its own valid bit, so a stalled result only blocks the
// stages behind it once they are all full, and req_stall rises only when
// every stage holds a transaction.
// Reset clears all valid bits and loads the documented register defaults.
// Registers must be written over the csr_ port only while no transaction is in flight; nothing enforces it.
`include "fdtd_acoustic_cell_update_defines.svh"
module fdtd_acoustic_cell_update (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fdtdac_pkg::req_type                req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fdtdac_pkg::rsp_type                rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fdtdac_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fdtdac_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fdtdac_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import fdtdac_pkg::*;

   cfg_type  cfg;
   num_type  num_data;
   logic     num_valid;
   logic     num_stall;
   mul_type  mul_data;
   logic     mul_valid;
   logic     mul_stall;
   logic     emit_wr;

   // Register file; the pipeline reads the live values.
   fdtdac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Stages one and two.
   fdtdac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (num_valid),
      .out_stall (num_stall),
      .out_data  (num_data)
   );

   // Stage three.
   fdtdac_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_stall  (num_stall),
      .in_data   (num_data),
      .out_valid (mul_valid),
      .out_stall (mul_stall),
      .out_data  (mul_data)
   );

   // Stage four, which is also the result register.
   fdtdac_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_stall  (mul_stall),
      .in_data   (mul_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign emit_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                    && (csr_paddr[CSR_ADDR_W-1:2] == REG_EMITTANCE);

   // Back-pressure only reaches the input once the whole pipe is full.
   `FDTDAC_ASSERT_SAME(a_stall_needs_full, clock, reset, req_stall, rsp_valid && rsp_stall && num_valid && mul_valid, "input stalled with room in the pipeline")
   `FDTDAC_ASSERT_NEXT(a_emit_write, clock, reset, emit_wr, cfg.emittance == $past(csr_pwdata[RECIP_W-1:0]), "emittance write not taken")

endmodule

@@ dv/fdtd_acoustic_cell_update_tb.sv @@
// Self-checking testbench for the FDTD acoustic cell update block.
module fdtd_acoustic_cell_update_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fdtdac_pkg::*;

   // Addresses above the last loss register decode to nothing.
   localparam logic [REG_IDX_W-1:0] REG_SPARE_LOW  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

   // Long output hold-off, and the quiet stretch that counts as a hang.
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QUIET_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int REPORT_LIMIT    = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Local copy of the loss registers; index of a reciprocal is the number
   // of missing neighbours it serves.
   logic [RECIP_W-1:0] emittance_q = EMITTANCE_RST;
   logic [RECIP_W-1:0] loss_recip_q [1:4] =
      '{RECIP_ONE_RST, RECIP_TWO_RST, RECIP_THREE_RST, RECIP_FOUR_RST};

   // Next-step pressures still owed by the block, oldest first.
   rsp_type expected_cells [$];

   int  mismatch_count   = 0;
   int  cells_sent       = 0;
   int  cells_checked    = 0;
   int  clips_seen       = 0;
   int  settings_used    = 1;
   int  input_stall_cycles = 0;
   bit  idling_on        = 1'b1;

   // Receiver-side bookkeeping; hold_offs_asked is bumped by the hold-off test, the rest only by the stall process.
   int  stall_left       = 0;
   int  hold_left        = 0;
   int  hold_offs_asked  = 0;
   int  hold_offs_taken  = 0;

   fdtd_acoustic_cell_update u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Computes the next pressure of one cell. The lossless update is kept in
   // half-LSB units and the loss numerator in 2^-17 LSB units, so that the
   // only rounding is the final floor after the reciprocal multiply.
   function automatic rsp_type next_pressure(input req_type site);
      rsp_type result;
      longint  center;
      longint  prior;
      longint  neighbour_sum;
      longint  twice_update;
      longint  numerator;
      longint  product;
      longint  y;
      int      open_count;
      int      missing;
      center        = longint'($signed(site.center_value));
      prior         = longint'($signed(site.previous_value));
      neighbour_sum = longint'($signed(site.north_value)) + longint'($signed(site.south_value))
                    + longint'($signed(site.west_value)) + longint'($signed(site.east_value));
      open_count    = int'(site.open_neighbours);
      if (open_count > 4) begin
         open_count = 4;
      end
      missing      = 4 - open_count;
      twice_update = missing * center + neighbour_sum - 2 * prior;
      if (missing == 0) begin
         y = twice_update >>> 1;
      end else begin
         numerator = twice_update * 65536
                   + 2 * longint'(emittance_q) * missing * prior;
         product   = numerator * longint'(loss_recip_q[missing]);
         y         = product >>> RND_SHIFT;
      end
      result.saturated = 1'b0;
      if (y > VAL_MAX) begin
         y = VAL_MAX;
         result.saturated = 1'b1;
      end else if (y < VAL_MIN) begin
         y = VAL_MIN;
         result.saturated = 1'b1;
      end
      result.next_value = y[VAL_W-1:0];
      // A wall cell holds its pressure.
      if (site.solid) begin
         result.next_value = site.center_value;
         result.saturated  = 1'b0;
      end
      return result;
   endfunction

   function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch, %s: expected %0d, got %0d", $realtime, what, want, got);
      end
   endfunction

   // Pressures are biased toward the extremes and toward small amplitudes,
   // which is where the floor and the clipping paths live.
   function automatic logic [VAL_W-1:0] random_pressure();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2, 3, 4: return 16'($urandom_range(0, 4095) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_cell();
      req_type site;
      site.center_value   = random_pressure();
      site.previous_value = random_pressure();
      site.north_value    = random_pressure();
      site.south_value    = random_pressure();
      site.west_value     = random_pressure();
      site.east_value     = random_pressure();
      // Counts above four are legal on the port and mean "all open".
      if ($urandom_range(0, 7) == 0) begin
         site.open_neighbours = 3'($urandom_range(5, 7));
      end else begin
         site.open_neighbours = 3'($urandom_range(0, 4));
      end
      site.solid = ($urandom_range(0, 7) == 0);
      return site;
   endfunction

   function automatic req_type make_cell(input int c, input int p, input int n,
                                         input int s, input int w, input int e,
                                         input int k, input bit wall);
      req_type site;
      site.center_value    = 16'(c);
      site.previous_value  = 16'(p);
      site.north_value     = 16'(n);
      site.south_value     = 16'(s);
      site.west_value      = 16'(w);
      site.east_value      = 16'(e);
      site.open_neighbours = 3'(k);
      site.solid           = wall;
      return site;
   endfunction

   // Offers one cell and holds it until the block takes it. The valid is
   // left high afterwards, so back-to-back calls stream without a bubble;
   // it only drops for a random idle burst or when the caller drains.
   task automatic send_cell(input req_type site);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= site;
      do begin
         @(posedge clock);
         if (req_stall) begin
            input_stall_cycles++;
         end
      end while (req_stall);
      expected_cells.push_back(next_pressure(site));
      cells_sent++;
   endtask

   task automatic send_random_cells(input int count);
      repeat (count) send_cell(random_cell());
   endtask

   // Stops offering and waits until every owed result has come back, then
   // lets the pipeline settle before any register is touched.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB write: setup cycle, then access until pready. The bus is left
   // selected so that a following transfer can start in the next cycle.
   task automatic csr_write(input logic [REG_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // Registers keep 16 bits; undecoded addresses change nothing.
      case (index)
         REG_EMITTANCE:   emittance_q     = value[RECIP_W-1:0];
         REG_RECIP_ONE:   loss_recip_q[1] = value[RECIP_W-1:0];
         REG_RECIP_TWO:   loss_recip_q[2] = value[RECIP_W-1:0];
         REG_RECIP_THREE: loss_recip_q[3] = value[RECIP_W-1:0];
         REG_RECIP_FOUR:  loss_recip_q[4] = value[RECIP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_read_check(input logic [REG_IDX_W-1:0] index);
      logic [RECIP_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_EMITTANCE:   want = emittance_q;
         REG_RECIP_ONE:   want = loss_recip_q[1];
         REG_RECIP_TWO:   want = loss_recip_q[2];
         REG_RECIP_THREE: want = loss_recip_q[3];
         default:         want = loss_recip_q[4];
      endcase
      if (csr_prdata[RECIP_W-1:0] !== want) begin
         note_mismatch($sformatf("register %0d read back", index), want,
                       csr_prdata[RECIP_W-1:0]);
      end
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_back_all();
      csr_read_check(REG_EMITTANCE);
      csr_read_check(REG_RECIP_ONE);
      csr_read_check(REG_RECIP_TWO);
      csr_read_check(REG_RECIP_THREE);
      csr_read_check(REG_RECIP_FOUR);
   endtask

   task automatic load_loss_settings(input logic [CSR_DATA_W-1:0] e,
                                     input logic [CSR_DATA_W-1:0] r1,
                                     input logic [CSR_DATA_W-1:0] r2,
                                     input logic [CSR_DATA_W-1:0] r3,
                                     input logic [CSR_DATA_W-1:0] r4);
      csr_write(REG_EMITTANCE, e);
      csr_write(REG_RECIP_ONE, r1);
      csr_write(REG_RECIP_TWO, r2);
      csr_write(REG_RECIP_THREE, r3);
      csr_write(REG_RECIP_FOUR, r4);
      read_back_all();
      csr_release();
      settings_used++;
   endtask

   // ---------------------------------------------------------------------
   // Test tasks, run in order from the main sequence below.
   // ---------------------------------------------------------------------

   // The registers must come out of reset with their documented defaults.
   task automatic test_reset_values();
      read_back_all();
      csr_release();
   endtask

   // Hand-picked cells: every open-neighbour count, counts above four, wall
   // cells, floors of negative halves and both clipping edges.
   task automatic test_directed_cells();
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 4, 1'b0));
      send_cell(make_cell(1, 0, 1, 0, 0, 0, 4, 1'b0));
      send_cell(make_cell(0, 0, -1, 0, 0, 0, 4, 1'b0));
      send_cell(make_cell(0, 0, 32767, 32767, 0, 0, 4, 1'b0));
      send_cell(make_cell(0, 0, 32767, 32767, 1, 0, 4, 1'b0));
      send_cell(make_cell(0, 0, 32767, 32767, 2, 0, 4, 1'b0));
      send_cell(make_cell(-32768, -32768, -32768, -32768, -32768, -32768, 4, 1'b0));
      send_cell(make_cell(32767, -32768, 32767, 32767, 32767, 32767, 4, 1'b0));
      send_cell(make_cell(-32768, 32767, -32768, -32768, -32768, -32768, 4, 1'b0));
      send_cell(make_cell(32767, -32768, 32767, 32767, 32767, 32767, 0, 1'b0));
      send_cell(make_cell(-32768, 32767, -32768, -32768, -32768, -32768, 0, 1'b0));
      send_cell(make_cell(150, -75, 20, -30, 40, 10, 0, 1'b0));
      send_cell(make_cell(1000, 200, 300, -400, 500, -600, 1, 1'b0));
      send_cell(make_cell(1000, 200, 300, -400, 500, -600, 2, 1'b0));
      send_cell(make_cell(-1000, -200, -300, 400, -500, 600, 3, 1'b0));
      send_cell(make_cell(0, -32768, 0, 0, 0, 0, 1, 1'b0));
      send_cell(make_cell(0, 1, 0, 0, 0, 0, 3, 1'b0));
      send_cell(make_cell(700, 300, 100, 200, -100, 50, 5, 1'b0));
      send_cell(make_cell(700, 300, 100, 200, -100, 51, 6, 1'b0));
      send_cell(make_cell(-700, 300, -32768, 200, -100, 51, 7, 1'b0));
      send_cell(make_cell(32767, -32768, 32767, 32767, 32767, 32767, 4, 1'b1));
      send_cell(make_cell(-32768, 32767, 32767, 32767, 32767, 32767, 0, 1'b1));
      send_cell(make_cell(-5, 9, -1, -1, -1, -1, 7, 1'b1));
   endtask

   task automatic test_default_losses();
      send_random_cells(380);
      wait_for_results();
   endtask

   // Loss settings from all-zero to all-ones, with junk in the upper data
   // bits, then a physically consistent set and a random one.
   task automatic test_loss_settings();
      load_loss_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_random_cells(200);
      wait_for_results();
      load_loss_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_random_cells(200);
      wait_for_results();
      load_loss_settings(32'd6554, 32'd59578, 32'd54613, 32'd50412, 32'd46811);
      send_random_cells(200);
      wait_for_results();
      load_loss_settings($urandom, $urandom, $urandom, $urandom, $urandom);
      send_random_cells(150);
      wait_for_results();
   endtask

   // Writes to undecoded addresses must leave every loss register alone.
   task automatic test_undecoded_writes();
      csr_write(REG_SPARE_LOW, 32'hDEAD_BEEF);
      csr_write(REG_SPARE_HIGH, 32'h1234_5678);
      read_back_all();
      csr_release();
      send_random_cells(100);
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while cells keep coming, so
   // the pipeline fills and the block has to push back on its input.
   task automatic test_output_hold_off();
      load_loss_settings({16'hA5A5, EMITTANCE_RST}, RECIP_ONE_RST, RECIP_TWO_RST,
                         RECIP_THREE_RST, RECIP_FOUR_RST);
      idling_on = 1'b0;
      hold_offs_asked++;
      send_random_cells(250);
      idling_on = 1'b1;
      wait_for_results();
   endtask

   // Full-rate streaming with no gaps on either side to finish.
   task automatic test_full_rate_stream();
      idling_on = 1'b0;
      send_random_cells(300);
      wait_for_results();
   endtask

   // Output side: random stall bursts, plus the long hold-off on request.
   // Only this process drives rsp_stall, once per clock edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_offs_taken != hold_offs_asked) begin
         hold_offs_taken = hold_offs_asked;
         hold_left       = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every accepted result is matched, field by field, against the oldest
   // pressure still owed.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cells.size() == 0) begin
            note_mismatch("result with nothing owed, next_value", 0, rsp_data.next_value);
         end else begin
            want = expected_cells.pop_front();
            cells_checked++;
            if (rsp_data.saturated === 1'b1) begin
               clips_seen++;
            end
            if (rsp_data.next_value !== want.next_value) begin
               note_mismatch("next_value", want.next_value, rsp_data.next_value);
            end
            if (rsp_data.saturated !== want.saturated) begin
               note_mismatch("saturated", want.saturated, rsp_data.saturated);
            end
         end
      end
   end

   // Ends the run when no transaction of any kind has moved for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_psel && csr_penable && csr_pready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("fdtd_acoustic_cell_update regression: fail");
      $finish;
   end

   // Main sequence: one reset, then the tests in turn.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed_cells();
      test_default_losses();
      test_loss_settings();
      test_undecoded_writes();
      test_output_hold_off();
      test_full_rate_stream();
      $display("Sent %0d cells and checked %0d results under %0d loss settings.",
               cells_sent, cells_checked, settings_used);
      $display("Results clipped: %0d; cycles with the input held back: %0d.",
               clips_seen, input_stall_cycles);
      if (mismatch_count == 0 && expected_cells.size() == 0) begin
         $display("fdtd_acoustic_cell_update regression: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  expected_cells.size());
         $display("fdtd_acoustic_cell_update regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/fdtdac_pkg.sv
rtl/fdtdac_csr.sv
rtl/fdtdac_front.sv
rtl/fdtdac_mul.sv
rtl/fdtdac_out.sv
rtl/fdtd_acoustic_cell_update.sv
dv/fdtd_acoustic_cell_update_tb.sv
